// ----- hw/rtl/affa_pkg.sv -----
package affa_pkg;

  localparam int ADDR_W = 20;   // byte address width
  localparam int REQ_W  = 16;   // request size width
  localparam int SIZE_W = 17;   // rounded size, 65533..65535 round to 65536
  localparam int SUM_W  = 18;   // fill plus rounded size never overflows this
  localparam int HEAP_W = 26;   // holds ARENA_COUNT * ARENA_BYTES at the largest config

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 20'h10000;
  localparam logic [SIZE_W-1:0] SIZE_ROUND    = 17'h3;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_ROOM     = 3'd1,
    ST_DOUBLE_FREE = 3'd2,
    ST_NULL_FREE   = 3'd3,
    ST_OUTSIDE     = 3'd4
  } status_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Request packet handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [HEAP_W-1:0] offset;  // block address minus heap base, for frees
    logic              done;    // some cell (or the entry checks) already answered
    status_e           status;
    logic [ADDR_W-1:0] gaddr;
  } pkt_t;

endpackage

// ----- hw/rtl/affa_cell.sv -----
module affa_cell
  import affa_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int ARENA_BYTES = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ADDR_W-1:0] heap_base_i,
  input  pkt_t              pkt_i,
  output pkt_t              pkt_o
);

  localparam int OW = $clog2(ARENA_BYTES);
  localparam logic [HEAP_W-1:0] LO = HEAP_W'(IDX * ARENA_BYTES);
  localparam logic [HEAP_W-1:0] HI = HEAP_W'((IDX + 1) * ARENA_BYTES);
  localparam logic [SUM_W-1:0]  LIMIT = SUM_W'(ARENA_BYTES);

  logic [OW-1:0]    fill_q, fill_d;
  logic [15:0]      count_q, count_d;
  pkt_t             pkt_q, pkt_d;
  logic [SUM_W-1:0] sum;
  logic             pending, fit, in_range, do_alloc, do_free;

  assign pending  = pkt_i.valid && !pkt_i.done;
  assign sum      = SUM_W'(fill_q) + SUM_W'(pkt_i.size);
  assign fit      = sum < LIMIT;
  assign in_range = (pkt_i.offset >= LO) && (pkt_i.offset < HI);
  assign do_alloc = pending && (pkt_i.op == OP_ALLOC) && fit;
  assign do_free  = pending && (pkt_i.op == OP_FREE) && in_range;

  always_comb begin
    fill_d  = fill_q;
    count_d = count_q;
    pkt_d   = pkt_i;
    if (do_alloc) begin
      fill_d       = sum[OW-1:0];
      count_d      = count_q + 16'd1;
      pkt_d.done   = 1'b1;
      pkt_d.status = ST_OK;
      pkt_d.gaddr  = heap_base_i + LO[ADDR_W-1:0] + ADDR_W'(fill_q);
    end else if (do_free) begin
      pkt_d.done = 1'b1;
      if (count_q == 16'd0) begin
        pkt_d.status = ST_DOUBLE_FREE;
      end else begin
        pkt_d.status = ST_OK;
        count_d      = count_q - 16'd1;
        // last live block gone: arena starts over
        if (count_q == 16'd1) begin
          fill_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
      pkt_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
      pkt_q   <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

// ----- hw/rtl/arena_first_fit_allocator.sv -----
// Arena first-fit heap allocator.
// Command channel: drive op_i, request_size_i and block_address_i with start
// high; the command is taken at a clock edge where start is high and busy is
// low. busy stays high until the result beat has been shown.
// Result channel: result_valid_o pulses for one cycle with granted_address_o
// and status_o. The receiver cannot stall; the beat must be taken then.
// Config channel: heap_base is written by cfg_valid_i/cfg_data_i; cfg_ready_o
// is always high. Write it only while busy is low.
// The state sits in a row of ARENA_COUNT cells, one per arena, each holding
// that arena's fill offset and live count. A command travels the row one cell
// per cycle; the first cell that answers marks it done.
// Pipeline: an accepted command passes the entry register, then one register
// per cell, and result_valid_o is driven from the last cell's register. busy
// drops at the edge that takes the result beat, so only one command is in the
// row at a time and the next one is taken only after that beat.
// Reset: all fills and counts clear at once, heap_base returns to 0x10000,
// any command in flight is dropped.
module arena_first_fit_allocator
  import affa_pkg::*;
#(
  parameter int ARENA_BYTES = 2048,
  parameter int ARENA_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              op_i,
  input  logic [REQ_W-1:0]  request_size_i,
  input  logic [ADDR_W-1:0] block_address_i,
  output logic              result_valid_o,
  output logic [ADDR_W-1:0] granted_address_o,
  output logic [2:0]        status_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ADDR_W-1:0] cfg_data_i
);

  localparam logic [HEAP_W-1:0] HEAP_LIMIT = HEAP_W'(ARENA_COUNT * ARENA_BYTES);

  logic [ADDR_W-1:0] base_q, base_d;
  logic              busy_q, busy_d;
  pkt_t              entry_q, entry_d;
  pkt_t              chain [ARENA_COUNT+1];
  pkt_t              tail;
  logic              accept;
  logic [HEAP_W-1:0] offset;
  logic              missed;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = 1'b1;
  assign offset      = HEAP_W'(block_address_i - base_q);

  always_comb begin
    base_d = cfg_valid_i ? cfg_data_i : base_q;
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tail.valid) begin
      busy_d = 1'b0;
    end

    entry_d        = '0;
    entry_d.valid  = accept;
    entry_d.op     = op_i;
    entry_d.size   = (SIZE_W'(request_size_i) + SIZE_ROUND) & ~SIZE_ROUND;
    entry_d.offset = offset;
    entry_d.status = ST_OK;
    if (op_i == OP_FREE) begin
      if (block_address_i == '0) begin
        entry_d.done   = 1'b1;
        entry_d.status = ST_NULL_FREE;
      end else if (block_address_i < base_q || offset >= HEAP_LIMIT) begin
        entry_d.done   = 1'b1;
        entry_d.status = ST_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= HEAP_BASE_RST;
      busy_q  <= 1'b0;
      entry_q <= '0;
    end else begin
      base_q  <= base_d;
      busy_q  <= busy_d;
      entry_q <= entry_d;
    end
  end

  assign chain[0] = entry_q;

  for (genvar i = 0; i < ARENA_COUNT; i++) begin : g_cell
    affa_cell #(
      .IDX         (i),
      .ARENA_BYTES (ARENA_BYTES)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .heap_base_i (base_q),
      .pkt_i       (chain[i]),
      .pkt_o       (chain[i+1])
    );
  end

  assign tail   = chain[ARENA_COUNT];
  // an allocate that no cell took found no room
  assign missed = !tail.done && (tail.op == OP_ALLOC);

  assign result_valid_o    = tail.valid;
  assign status_o          = missed ? ST_NO_ROOM : tail.status;
  assign granted_address_o = (tail.done && tail.op == OP_ALLOC && tail.status == ST_OK)
                             ? tail.gaddr : '0;

endmodule

// ----- hw/rtl/affa_checker.sv -----
module affa_checker
  import affa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input logic [ADDR_W-1:0] granted_address_o,
  input logic [2:0]        status_o
);

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result beat outside a busy window");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted command did not raise busy or answered too early");

  a_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!busy && !result_valid_o))
    else $error("busy held past result beat");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |-> (granted_address_o == '0))
    else $error("address granted on a failed command");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o <= ST_OUTSIDE))
    else $error("status code out of range");

endmodule

bind arena_first_fit_allocator affa_checker u_affa_checker (.*);
